@@ design/slip_dec_pkg.sv @@
// shared types and constants for the slip frame decoder
package slip_dec_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_FIELD_W = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;

    // result kinds carried on the output channel
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } result_kind_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_END_CODE       = 3'd0,
        CFG_ESCAPE_CODE    = 3'd1,
        CFG_ESC_END_CODE   = 3'd2,
        CFG_ESC_ESC_CODE   = 3'd3,
        CFG_MAX_FRAME_LEN  = 3'd4
    } cfg_index_t;

    // rfc 1055 reset values
    localparam logic [BYTE_W-1:0]      END_CODE_RST     = 8'd192;
    localparam logic [BYTE_W-1:0]      ESCAPE_CODE_RST  = 8'd219;
    localparam logic [BYTE_W-1:0]      ESC_END_CODE_RST = 8'd220;
    localparam logic [BYTE_W-1:0]      ESC_ESC_CODE_RST = 8'd221;
    localparam logic [LEN_FIELD_W-1:0] MAX_FRAME_RST    = 12'd1006;

    // one result beat
    typedef struct packed {
        result_kind_t            kind;
        logic [BYTE_W-1:0]       data;
        logic [LEN_FIELD_W-1:0]  len;
    } result_t;

endpackage

@@ design/slip_frame_decoder.sv @@
// slip frame decoder: byte-wise slip unframing with an output skid stage
//
// Takes one line byte per cycle while in_stall is low, and gives at most one
// result beat per byte: a decoded payload byte, a frame-complete beat with
// the frame length, or an abort beat. Each accepted byte is decoded in the
// cycle it is taken; its result is registered in the output register, or in
// the skid register while an output beat is held. A two-entry output stage
// (output register plus skid register) lets a byte be taken while a result
// still waits; in_stall rises only once the skid register is full.
// The special codes and the frame limit are written through the cfg port,
// which is always ready, and should be changed only while the block is idle.
module slip_frame_decoder
    import slip_dec_pkg::*;
#(
    parameter int LENGTH_WIDTH = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // byte input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [BYTE_W-1:0]       rx_byte,
    // result output
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              result_kind,
    output logic [BYTE_W-1:0]       payload_byte,
    output logic [LEN_FIELD_W-1:0]  frame_length,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CMP_W = (LENGTH_WIDTH > LEN_FIELD_W) ? LENGTH_WIDTH : LEN_FIELD_W;
    localparam logic [LENGTH_WIDTH-1:0] COUNT_TOP = {LENGTH_WIDTH{1'b1}};

    // configuration registers
    logic [BYTE_W-1:0]      end_code_reg;
    logic [BYTE_W-1:0]      escape_code_reg;
    logic [BYTE_W-1:0]      esc_end_code_reg;
    logic [BYTE_W-1:0]      esc_esc_code_reg;
    logic [LEN_FIELD_W-1:0] max_frame_len_reg;

    // decoder state
    logic                    resync_reg;
    logic                    resync_next;
    logic                    escape_reg;
    logic                    escape_next;
    logic [LENGTH_WIDTH-1:0] count_reg;
    logic [LENGTH_WIDTH-1:0] count_next;

    // output stage
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    in_accept;
    logic    out_free;
    logic    produce;
    result_t result;

    logic [BYTE_W-1:0] data_byte;
    logic              is_data;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  max_ext;
    logic              over_limit;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign count_ext  = CMP_W'(count_reg);
    assign max_ext    = CMP_W'(max_frame_len_reg);
    assign over_limit = (count_ext >= max_ext) || (count_reg == COUNT_TOP);

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_code_reg      <= END_CODE_RST;
            escape_code_reg   <= ESCAPE_CODE_RST;
            esc_end_code_reg  <= ESC_END_CODE_RST;
            esc_esc_code_reg  <= ESC_ESC_CODE_RST;
            max_frame_len_reg <= MAX_FRAME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_END_CODE:      end_code_reg      <= cfg_data[BYTE_W-1:0];
                CFG_ESCAPE_CODE:   escape_code_reg   <= cfg_data[BYTE_W-1:0];
                CFG_ESC_END_CODE:  esc_end_code_reg  <= cfg_data[BYTE_W-1:0];
                CFG_ESC_ESC_CODE:  esc_esc_code_reg  <= cfg_data[BYTE_W-1:0];
                CFG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data[LEN_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // decode one byte against the current framing state
    always_comb
    begin
        resync_next = resync_reg;
        escape_next = escape_reg;
        count_next  = count_reg;
        produce     = 1'b0;
        result      = '{kind: KIND_BYTE, data: '0, len: '0};
        data_byte   = rx_byte;
        is_data     = 1'b0;

        if (resync_reg)
        begin
            if (rx_byte == end_code_reg)
                resync_next = 1'b0;
        end
        else if (escape_reg)
        begin
            escape_next = 1'b0;
            if (rx_byte == esc_end_code_reg)
            begin
                data_byte = end_code_reg;
                is_data   = 1'b1;
            end
            else if (rx_byte == esc_esc_code_reg)
            begin
                data_byte = escape_code_reg;
                is_data   = 1'b1;
            end
            else
            begin
                // bad escape pair
                count_next  = '0;
                resync_next = 1'b1;
                produce     = 1'b1;
                result.kind = KIND_ABORT;
            end
        end
        else if (rx_byte == end_code_reg)
        begin
            count_next = '0;
            if (count_reg != '0)
            begin
                produce     = 1'b1;
                result.kind = KIND_DONE;
                result.len  = count_ext[LEN_FIELD_W-1:0];
            end
        end
        else if (rx_byte == escape_code_reg)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            is_data = 1'b1;
        end

        // payload byte, checked against the frame limit
        if (is_data)
        begin
            produce = 1'b1;
            if (over_limit)
            begin
                count_next  = '0;
                escape_next = 1'b0;
                resync_next = 1'b1;
                result.kind = KIND_ABORT;
            end
            else
            begin
                count_next  = count_reg + LENGTH_WIDTH'(1);
                result.kind = KIND_BYTE;
                result.data = data_byte;
            end
        end
    end

    // framing state update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resync_reg <= 1'b0;
            escape_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (in_accept)
        begin
            resync_reg <= resync_next;
            escape_reg <= escape_next;
            count_reg  <= count_next;
        end
    end

    // output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept && produce;
            end
        end
        else if (in_accept && produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload of the output stage
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= result;
        end
        else if (in_accept && produce)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_reg.kind;
    assign payload_byte = out_reg.data;
    assign frame_length = out_reg.len;

    // skid register only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a completed frame always carries a nonzero length
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_DONE)) |-> (out_reg.len != '0))
        else $error("frame complete beat with zero length");

    // an abort puts the decoder into resync
    a_abort_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && produce && (result.kind == KIND_ABORT)) |=> resync_reg)
        else $error("abort did not enter resync");

    // escape state never survives into resync
    a_no_escape_in_resync: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> !resync_reg)
        else $error("escape pending while resynchronizing");

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the slip frame decoder
module testbench;
    import slip_dec_pkg::*;

    // what the predictor expects for one offered line byte
    typedef struct {
        bit      pinned;
        bit      has_result;
        result_t result;
    } line_note_t;

    // one row of the directed stimulus table
    typedef struct {
        logic [BYTE_W-1:0]      rx;
        bit                     pinned;
        bit                     has_result;
        result_kind_t           kind;
        logic [BYTE_W-1:0]      data;
        logic [LEN_FIELD_W-1:0] len;
    } table_row_t;

    localparam int DIR_ROWS = 21;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             result_kind;
    logic [BYTE_W-1:0]      payload_byte;
    logic [LEN_FIELD_W-1:0] frame_length;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers and the framing state
    logic [BYTE_W-1:0]      end_code_m  = END_CODE_RST;
    logic [BYTE_W-1:0]      esc_code_m  = ESCAPE_CODE_RST;
    logic [BYTE_W-1:0]      esc_end_m   = ESC_END_CODE_RST;
    logic [BYTE_W-1:0]      esc_esc_m   = ESC_ESC_CODE_RST;
    logic [LEN_FIELD_W-1:0] max_len_m   = MAX_FRAME_RST;
    bit                     resync_m    = 1'b0;
    bit                     esc_pend_m  = 1'b0;
    logic [LEN_FIELD_W-1:0] count_m     = '0;

    line_note_t offered_q[$];
    result_t    decoded_q[$];

    int  mismatch_count  = 0;
    int  line_bytes_sent = 0;
    int  burst_left      = 0;
    int  payload_seen    = 0;
    int  frames_seen     = 0;
    int  aborts_seen     = 0;
    bit  squeeze_req     = 1'b0;

    cfg_index_t reg_order [5] = '{CFG_END_CODE, CFG_ESCAPE_CODE, CFG_ESC_END_CODE,
                                  CFG_ESC_ESC_CODE, CFG_MAX_FRAME_LEN};

    // directed rows, under the reset codes c0 / db / dc / dd
    table_row_t dir_rows [DIR_ROWS] = '{
        '{8'hC0, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},  // empty frame dropped
        '{8'h00, 1'b1, 1'b1, KIND_BYTE,  8'h00, 12'd0},
        '{8'hFF, 1'b1, 1'b1, KIND_BYTE,  8'hFF, 12'd0},
        '{8'hDB, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hDC, 1'b1, 1'b1, KIND_BYTE,  8'hC0, 12'd0},  // literal end code
        '{8'hDB, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hDD, 1'b1, 1'b1, KIND_BYTE,  8'hDB, 12'd0},  // literal escape code
        '{8'h5A, 1'b0, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hC0, 1'b1, 1'b1, KIND_DONE,  8'h00, 12'd5},
        '{8'hDB, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'h41, 1'b1, 1'b1, KIND_ABORT, 8'h00, 12'd0},  // bad escape
        '{8'h42, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},  // ignored while resyncing
        '{8'hDB, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hDC, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hC0, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},  // end code leaves resync
        '{8'h7E, 1'b0, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hDB, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hC0, 1'b1, 1'b1, KIND_ABORT, 8'h00, 12'd0},  // end code after escape
        '{8'hC0, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hC0, 1'b1, 1'b0, KIND_BYTE,  8'h00, 12'd0},
        '{8'hDD, 1'b0, 1'b0, KIND_BYTE,  8'h00, 12'd0}   // bare escaped code is data
    };

    slip_frame_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // abort the frame and wait for the next end code
    function automatic bit enter_resync(output result_t res);
        count_m    = '0;
        esc_pend_m = 1'b0;
        resync_m   = 1'b1;
        res        = '0;
        res.kind   = KIND_ABORT;
        return 1'b1;
    endfunction

    // unframe one line byte, returns whether a result beat follows
    function automatic bit decode_line_byte(input logic [BYTE_W-1:0] rx, output result_t res);
        logic [BYTE_W-1:0]      c;
        logic [LEN_FIELD_W-1:0] n;
        c   = rx;
        res = '0;
        if (resync_m)
        begin
            if (c == end_code_m)
                resync_m = 1'b0;
            return 1'b0;
        end
        if (esc_pend_m)
        begin
            esc_pend_m = 1'b0;
            if (c == esc_end_m)
                c = end_code_m;
            else if (c == esc_esc_m)
                c = esc_code_m;
            else
                return enter_resync(res);
        end
        else if (c == end_code_m)
        begin
            n       = count_m;
            count_m = '0;
            if (n == '0)
                return 1'b0;
            res.kind = KIND_DONE;
            res.len  = n;
            return 1'b1;
        end
        else if (c == esc_code_m)
        begin
            esc_pend_m = 1'b1;
            return 1'b0;
        end
        if (count_m >= max_len_m || count_m == '1)
            return enter_resync(res);
        count_m  = count_m + LEN_FIELD_W'(1);
        res.kind = KIND_BYTE;
        res.data = c;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    endtask

    // check result beats, then predict for accepted line bytes
    always @(posedge clk)
    begin : beat_monitor
        result_t    want;
        result_t    pred;
        bit         has;
        line_note_t nt;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch("unexpected result beat", -1, int'(result_kind));
                else
                begin
                    want = decoded_q.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch("result_kind", int'(want.kind), int'(result_kind));
                    if (payload_byte !== want.data)
                        report_mismatch("payload_byte", int'(want.data), int'(payload_byte));
                    if (frame_length !== want.len)
                        report_mismatch("frame_length", int'(want.len), int'(frame_length));
                end
                case (result_kind)
                    KIND_BYTE:  payload_seen++;
                    KIND_DONE:  frames_seen++;
                    KIND_ABORT: aborts_seen++;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (offered_q.size() == 0)
                    report_mismatch("unexpected line byte accept", -1, int'(rx_byte));
                else
                begin
                    nt  = offered_q.pop_front();
                    has = decode_line_byte(rx_byte, pred);
                    if (nt.pinned)
                    begin
                        has  = nt.has_result;
                        pred = nt.result;
                    end
                    if (has)
                        decoded_q.push_back(pred);
                end
            end
        end
    end

    // offer one line byte in bursts with random gaps
    task automatic send_line_byte(input logic [BYTE_W-1:0] rx, input line_note_t nt);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        offered_q.push_back(nt);
        in_valid <= 1'b1;
        rx_byte  <= rx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        line_bytes_sent++;
    endtask

    task automatic send_plain(input logic [BYTE_W-1:0] rx);
        line_note_t nt;
        nt.pinned     = 1'b0;
        nt.has_result = 1'b0;
        nt.result     = '0;
        send_line_byte(rx, nt);
    endtask

    // slip-encode one payload byte under the current codes
    task automatic send_payload(input logic [BYTE_W-1:0] v);
        if (v == end_code_m)
        begin
            send_plain(esc_code_m);
            send_plain(esc_end_m);
        end
        else if (v == esc_code_m)
        begin
            send_plain(esc_code_m);
            send_plain(esc_esc_m);
        end
        else
            send_plain(v);
    endtask

    // payload values lean on the special codes
    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return end_code_m;
            1:       return esc_code_m;
            2:       return esc_end_m;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // frame lengths straddle the limit when it is small
    function automatic int pick_frame_len();
        if (max_len_m <= 64)
            return $urandom_range(0, max_len_m + 2);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 12);
    endfunction

    // mostly well-formed frames, some broken escapes, noise and spare end codes
    task automatic send_frames(input int n_bytes);
        int stop_at;
        int choice;
        int len;
        stop_at = line_bytes_sent + n_bytes;
        while (line_bytes_sent < stop_at)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 80)
            begin
                len = pick_frame_len();
                for (int i = 0; i < len; i++)
                    send_payload(pick_payload());
                send_plain(end_code_m);
            end
            else if (choice < 90)
            begin
                repeat ($urandom_range(0, 4)) send_payload(pick_payload());
                send_plain(esc_code_m);
                send_plain(BYTE_W'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) send_plain(BYTE_W'($urandom_range(0, 255)));
                send_plain(end_code_m);
            end
            else if (choice < 96)
            begin
                repeat ($urandom_range(1, 8)) send_plain(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_plain(end_code_m);
            end
        end
    endtask

    // drop valid and wait for every expected beat, plus the pipeline latency
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all five registers back to back while idle
    task automatic write_config(input logic [BYTE_W-1:0] e, input logic [BYTE_W-1:0] x,
                                input logic [BYTE_W-1:0] xe, input logic [BYTE_W-1:0] xx,
                                input logic [LEN_FIELD_W-1:0] lim);
        logic [CFG_DATA_W-1:0] vals [5];
        vals[0] = CFG_DATA_W'(e);
        vals[1] = CFG_DATA_W'(x);
        vals[2] = CFG_DATA_W'(xe);
        vals[3] = CFG_DATA_W'(xx);
        vals[4] = CFG_DATA_W'(lim);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (reg_order[i])
                CFG_END_CODE:      end_code_m = vals[i][BYTE_W-1:0];
                CFG_ESCAPE_CODE:   esc_code_m = vals[i][BYTE_W-1:0];
                CFG_ESC_END_CODE:  esc_end_m  = vals[i][BYTE_W-1:0];
                CFG_ESC_ESC_CODE:  esc_esc_m  = vals[i][BYTE_W-1:0];
                CFG_MAX_FRAME_LEN: max_len_m  = vals[i][LEN_FIELD_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // receiver: free runs, random stalls and occasional long hold-offs
    initial
    begin : receiver
        int mode;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 19);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
            end
            else if (mode == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else if (mode < 8)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(4, 40)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(4, 40))
                begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge clk);
                end
            end
        end
    end

    // main stimulus
    initial
    begin : stimulus
        line_note_t      nt;
        logic [BYTE_W-1:0] e;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_END_CODE;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset codes
        foreach (dir_rows[i])
        begin
            nt.pinned      = dir_rows[i].pinned;
            nt.has_result  = dir_rows[i].has_result;
            nt.result      = '0;
            nt.result.kind = dir_rows[i].kind;
            nt.result.data = dir_rows[i].data;
            nt.result.len  = dir_rows[i].len;
            send_line_byte(dir_rows[i].rx, nt);
        end

        // reset codes, with one long receiver hold-off
        squeeze_req = 1'b1;
        send_frames(420);
        settle();

        // extreme codes and a one-byte frame limit
        write_config(8'h00, 8'hFF, 8'h01, 8'hFE, 12'd1);
        send_frames(200);
        settle();

        // end equal to escape, both escaped codes equal, widest limit
        write_config(8'h7E, 8'h7E, 8'hFF, 8'hFF, 12'd4095);
        send_frames(250);
        settle();

        // escaped end equals escape, escaped escape equals end
        write_config(8'hFF, 8'h00, 8'h00, 8'hFF, 12'd5);
        send_frames(250);
        settle();

        // random distinct end and escape codes, small random limit
        e = BYTE_W'($urandom_range(0, 255));
        write_config(e, e + 8'($urandom_range(1, 255)), BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)), LEN_FIELD_W'($urandom_range(2, 40)));
        send_frames(350);
        settle();

        repeat (8) @(posedge clk);
        if (decoded_q.size() != 0)
            report_mismatch("beats never delivered", 0, decoded_q.size());
        $display("covered %0d line bytes over five register settings", line_bytes_sent);
        $display("saw %0d payload beats, %0d frames, %0d aborts",
                 payload_seen, frames_seen, aborts_seen);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
